// ----- hw/rtl/sbcpu_pkg.sv -----
// ----------------------------------------------------------------------------
// sbcpu_pkg
// Shared types and constants for the 16-bit instruction CPU step block.
// ----------------------------------------------------------------------------
package sbcpu_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [15:0] STOP_WORD = 16'hD000;
  localparam logic [13:0] ADDR_MASK = 14'h3FFF;

  localparam logic [3:0] R_SP = 4'd13;
  localparam logic [3:0] R_LR = 4'd14;
  localparam logic [3:0] R_PC = 4'd15;

  // opcodes (bits 15:12)
  localparam logic [3:0] OP_ALU  = 4'h0;
  localparam logic [3:0] OP_LDST = 4'h2;
  localparam logic [3:0] OP_MOVI = 4'h4;
  localparam logic [3:0] OP_CMPI = 4'h5;
  localparam logic [3:0] OP_ADDI = 4'h6;
  localparam logic [3:0] OP_SUBI = 4'h7;
  localparam logic [3:0] OP_PUSH = 4'hB;
  localparam logic [3:0] OP_BCC  = 4'hC;
  localparam logic [3:0] OP_B    = 4'hE;
  localparam logic [3:0] OP_BL   = 4'hF;

  // register ALU selects
  localparam logic [3:0] A_AND = 4'h0;
  localparam logic [3:0] A_EOR = 4'h1;
  localparam logic [3:0] A_SUB = 4'h2;
  localparam logic [3:0] A_SXB = 4'h3;
  localparam logic [3:0] A_ADD = 4'h4;
  localparam logic [3:0] A_ADC = 4'h5;
  localparam logic [3:0] A_LSR = 4'h6;
  localparam logic [3:0] A_LSL = 4'h7;
  localparam logic [3:0] A_TST = 4'h8;
  localparam logic [3:0] A_TEQ = 4'h9;
  localparam logic [3:0] A_CMP = 4'hA;
  localparam logic [3:0] A_ROR = 4'hB;
  localparam logic [3:0] A_ORR = 4'hC;
  localparam logic [3:0] A_MOV = 4'hD;
  localparam logic [3:0] A_BIC = 4'hE;
  localparam logic [3:0] A_MVN = 4'hF;

  // branch conditions (bits 11:8 of a relative branch)
  localparam logic [3:0] CC_EQ = 4'h0;
  localparam logic [3:0] CC_NE = 4'h1;
  localparam logic [3:0] CC_CS = 4'h2;
  localparam logic [3:0] CC_CC = 4'h3;
  localparam logic [3:0] CC_MI = 4'h4;
  localparam logic [3:0] CC_PL = 4'h5;
  localparam logic [3:0] CC_HI = 4'h8;
  localparam logic [3:0] CC_LS = 4'h9;
  localparam logic [3:0] CC_AL = 4'hE;

  typedef struct packed {
    logic [1:0]  command;
    logic [13:0] address;
    logic [7:0]  write_byte;
    logic [3:0]  reg_select;
  } sbcpu_in_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [31:0] reg_value;
    logic [31:0] program_counter;
    logic [15:0] instr_word;
    logic        neg_flag;
    logic        carry_flag;
    logic        zero_flag;
    logic        halted;
  } sbcpu_out_t;

  // ALU request / response
  typedef struct packed {
    logic [3:0]  sel;
    logic [31:0] a;
    logic [31:0] b;
    logic        cin;
  } sbcpu_alu_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        c;
    logic        c_upd;
    logic        wr;
  } sbcpu_alu_rsp_t;

endpackage

// ----- hw/rtl/sbcpu_alu.sv -----
// ----------------------------------------------------------------------------
// sbcpu_alu
// Shared arithmetic, logic and shift unit; results are registered by the
// sequencer that uses it.
// ----------------------------------------------------------------------------
module sbcpu_alu (
  input  sbcpu_pkg::sbcpu_alu_req_t req,
  output sbcpu_pkg::sbcpu_alu_rsp_t rsp
);
  import sbcpu_pkg::*;

  logic [32:0] sum;
  logic [32:0] dif;
  logic        big;
  logic [4:0]  sh;
  logic [4:0]  shm1;
  logic [63:0] rr;

  always_comb begin
    sum  = {1'b0, req.a} + {1'b0, req.b} + {32'd0, req.cin};
    dif  = {1'b0, req.a} - {1'b0, req.b};
    big  = |req.b[31:6] || (req.b[5] && |req.b[4:0]);
    sh   = req.b[4:0];
    shm1 = sh - 5'd1;
    rr   = {req.a, req.a} >> sh;
    rsp  = '0;
    rsp.wr = 1'b1;
    case (req.sel)
      A_AND: rsp.res = req.a & req.b;
      A_EOR: rsp.res = req.a ^ req.b;
      A_SUB, A_CMP: begin
        rsp.res = dif[31:0]; rsp.c = ~dif[32]; rsp.c_upd = 1'b1;
      end
      A_SXB: rsp.res = {{24{req.b[7]}}, req.b[7:0]};
      A_ADD, A_ADC: begin
        rsp.res = sum[31:0]; rsp.c = sum[32]; rsp.c_upd = 1'b1;
      end
      A_LSR: begin
        rsp.res = req.a;
        if (big) begin
          rsp.res = '0; rsp.c_upd = 1'b1;
        end else if (req.b[5]) begin
          rsp.res = '0; rsp.c = req.a[31]; rsp.c_upd = 1'b1;
        end else if (sh != 5'd0) begin
          rsp.res = req.a >> sh; rsp.c = req.a[shm1]; rsp.c_upd = 1'b1;
        end
      end
      A_LSL: begin
        rsp.res = req.a;
        if (big) begin
          rsp.res = '0; rsp.c_upd = 1'b1;
        end else if (req.b[5]) begin
          rsp.res = '0; rsp.c = req.a[0]; rsp.c_upd = 1'b1;
        end else if (sh != 5'd0) begin
          rsp.res = req.a << sh; rsp.c = req.a[5'd0 - sh]; rsp.c_upd = 1'b1;
        end
      end
      A_TST: begin
        rsp.res = req.a & req.b; rsp.wr = 1'b0;
      end
      A_TEQ: begin
        rsp.res = req.a ^ req.b; rsp.wr = 1'b0;
      end
      A_ROR: begin
        rsp.res = rr[31:0];
        if (req.b != 32'd0) begin
          rsp.c = req.a[shm1]; rsp.c_upd = 1'b1;
        end
      end
      A_ORR: rsp.res = req.a | req.b;
      A_MOV: rsp.res = req.b;
      A_BIC: rsp.res = req.a & ~req.b;
      default: rsp.res = ~req.b;
    endcase
    if (req.sel == A_CMP) rsp.wr = 1'b0;
  end
endmodule

// ----- hw/rtl/sixteen_bit_isa_cpu_step.sv -----
// ----------------------------------------------------------------------------
// sixteen_bit_isa_cpu_step
// Command-driven step of a small CPU: byte memory access, one-instruction
// execute, register clear.
// ----------------------------------------------------------------------------
// Rate: one transaction at a time; in_ready is low from acceptance until the
// result is taken. Memory read and write commands go straight to the response;
// register clear passes a clearing step first. An execute passes through
// accept, a two-byte fetch and decode; branches and unused opcodes then go
// to the response, ALU and immediate ops through an execute step, loads and
// stores byte by byte through memory, push and pull word by word through a
// list walk. The byte memory is single port with a registered read. Memory
// contents are zero after reset only after a clearing pass over all
// MEM_BYTES bytes, during which in_ready is low.
module sixteen_bit_isa_cpu_step #(
  parameter int MEM_BYTES = 16384
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sbcpu_pkg::sbcpu_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sbcpu_pkg::sbcpu_out_t  out_data
);
  import sbcpu_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  // reciprocal for the address reduction, exact for 14-bit addresses
  localparam int RECIP = ((1 << 30) + MEM_BYTES - 1) / MEM_BYTES;

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_MEMRD = 13'b0000000000100,
    S_FET   = 13'b0000000001000,
    S_DEC   = 13'b0000000010000,
    S_RDA   = 13'b0000000100000,
    S_EXE   = 13'b0000001000000,
    S_MEM   = 13'b0000010000000,
    S_MEMW  = 13'b0000100000000,
    S_LIST  = 13'b0001000000000,
    S_RCLR  = 13'b0010000000000,
    S_RSP   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t      state_r, state_nxt;
  sbcpu_in_t   cmd_r;
  logic [31:0] rf_r [16];
  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  mrd_r;
  logic [AW-1:0] clr_r;
  logic [15:0] ir_r;
  logic        n_r, c_r, z_r;
  logic [31:0] a_r, b_r, adr_r, wd_r;
  logic [1:0]  k_r;
  logic [3:0]  idx_r;
  logic [3:0]  dst_r;
  logic [1:0]  nby_r;
  logic [4:0]  phase_r;
  logic        out_v_r;
  sbcpu_out_t  out_r;
  sbcpu_alu_req_t alu_req;
  sbcpu_alu_rsp_t alu_rsp;

  // physical byte address: 14-bit mask, then reduce modulo MEM_BYTES
  function automatic logic [AW-1:0] phys(input logic [31:0] a);
    logic [13:0] m;
    logic [34:0] prod;
    logic [4:0]  q;
    logic [31:0] r;
    m = a[13:0] & ADDR_MASK;
    prod = {21'd0, m} * 35'(RECIP);
    q = prod[34:30];
    r = {18'd0, m} - 32'(q) * 32'(MEM_BYTES);
    phys = AW'(r);
  endfunction

  logic        mem_we;
  logic [AW-1:0] mem_a;
  logic [7:0]  mem_wd;

  assign alu_req.sel = ir_r[15:12] == OP_ALU ? ir_r[11:8] :
                       ir_r[15:12] == OP_ADDI ? A_ADD :
                       ir_r[15:12] == OP_MOVI ? A_MOV : A_SUB;
  assign alu_req.a   = a_r;
  assign alu_req.b   = ir_r[15:12] == OP_ALU ? b_r : {24'd0, ir_r[11:4]};
  assign alu_req.cin = (ir_r[15:12] == OP_ALU && ir_r[11:8] == A_ADC) ? c_r : 1'b0;

  sbcpu_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  // memory port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_a] <= mem_wd;
    mrd_r <= mem[mem_a];
  end

  logic bcc_ok;
  always_comb begin
    case (ir_r[11:8])
      CC_EQ: bcc_ok = z_r;
      CC_NE: bcc_ok = ~z_r;
      CC_CS: bcc_ok = c_r;
      CC_CC: bcc_ok = ~c_r;
      CC_MI: bcc_ok = n_r;
      CC_PL: bcc_ok = ~n_r;
      CC_HI: bcc_ok = c_r & ~z_r;
      CC_LS: bcc_ok = ~c_r & z_r;
      CC_AL: bcc_ok = 1'b1;
      default: bcc_ok = 1'b0;
    endcase
  end

  // list scan: next set bit in push (descending) or pull (ascending) order
  logic [3:0] lpos;
  logic       lfound;
  always_comb begin
    lpos = '0; lfound = 1'b0;
    if (!ir_r[11]) begin
      for (int i = 0; i < 8; i++)
        if (ir_r[i] && 4'(i) < idx_r) begin lpos = 4'(i); lfound = 1'b1; end
    end else begin
      for (int i = 7; i >= 0; i--)
        if (ir_r[i] && 4'(i) >= idx_r) begin lpos = 4'(i); lfound = 1'b1; end
    end
  end

  logic [3:0] base;
  assign base = ir_r[10] ? 4'd8 : 4'd0;

  always_comb begin
    mem_we = 1'b0; mem_wd = wd_r[31:24]; mem_a = phys(adr_r + {30'd0, k_r});
    case (state_r)
      S_CLR: begin mem_we = 1'b1; mem_a = clr_r; mem_wd = '0; end
      S_IDLE: begin
        mem_a = phys({18'd0, in_data.address});
        mem_wd = in_data.write_byte;
        mem_we = in_valid && in_data.command == CMD_WRITE;
      end
      S_MEMW: mem_we = 1'b1;
      S_RSP: mem_a = phys({18'd0, cmd_r.address});
      default: ;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: if (clr_r == AW'(MEM_BYTES - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_valid) begin
        case (in_data.command)
          CMD_EXEC: state_nxt = S_FET;
          CMD_CLEAR: state_nxt = S_RCLR;
          default: state_nxt = S_RSP;
        endcase
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; out_v_r <= 1'b0;
      ir_r <= '0; n_r <= 1'b0; c_r <= 1'b0; z_r <= 1'b0;
      for (int i = 0; i < 16; i++) rf_r[i] <= '0;
      phase_r <= '0; k_r <= '0; idx_r <= '0;
      nby_r <= '0;
    end else begin
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          state_r <= state_nxt;
        end
        S_IDLE: begin
          state_r <= state_nxt;
          if (in_valid) begin
            cmd_r <= in_data;
            adr_r <= rf_r[R_PC]; k_r <= '0; phase_r <= '0;
          end
        end
        // two-byte fetch; each byte is addressed and then taken from the registered read
        S_FET: begin
          phase_r <= phase_r + 5'd1;
          if (phase_r == 5'd0) k_r <= 2'd1;
          if (phase_r == 5'd1) ir_r[15:8] <= mrd_r;
          if (phase_r == 5'd2) begin
            ir_r[7:0] <= mrd_r;
            rf_r[R_PC] <= rf_r[R_PC] + 32'd2;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          a_r <= rf_r[ir_r[3:0]];
          b_r <= rf_r[ir_r[7:4]];
          case (ir_r[15:12])
            OP_BCC: begin
              if (bcc_ok)
                rf_r[R_PC] <= rf_r[R_PC] + {{24{ir_r[7]}}, ir_r[7:0]};
              state_r <= S_RSP;
            end
            OP_B: begin rf_r[R_PC] <= {20'd0, ir_r[11:0]}; state_r <= S_RSP; end
            OP_BL: begin
              rf_r[R_LR] <= rf_r[R_PC];
              rf_r[R_PC] <= {20'd0, ir_r[11:0]};
              state_r <= S_RSP;
            end
            OP_LDST: begin
              adr_r <= rf_r[ir_r[7:4]]; k_r <= '0; phase_r <= '0;
              wd_r <= ir_r[10] ? {rf_r[ir_r[3:0]][7:0], 24'd0} : rf_r[ir_r[3:0]];
              nby_r <= ir_r[10] ? 2'd0 : 2'd3;
              dst_r <= ir_r[3:0];
              state_r <= ir_r[11] ? S_MEM : S_MEMW;
            end
            OP_PUSH: begin
              idx_r <= ir_r[11] ? 4'd0 : 4'd8;
              phase_r <= ir_r[8] ? 5'd1 : 5'd0;
              state_r <= S_LIST;
            end
            OP_ALU, OP_MOVI, OP_CMPI, OP_ADDI, OP_SUBI: state_r <= S_EXE;
            default: state_r <= S_RSP;
          endcase
        end
        S_EXE: begin
          n_r <= alu_rsp.res[31];
          z_r <= alu_rsp.res == 32'd0;
          if (ir_r[15:12] != OP_MOVI && (ir_r[15:12] != OP_ALU || alu_rsp.c_upd))
            c_r <= alu_rsp.c;
          if (ir_r[15:12] != OP_CMPI && alu_rsp.wr) rf_r[ir_r[3:0]] <= alu_rsp.res;
          state_r <= S_RSP;
        end
        // push/pull list walk; phase_r[0] marks the pending link/PC slot
        S_LIST: begin
          k_r <= '0; phase_r[4:1] <= '0; nby_r <= 2'd3;
          if (!ir_r[11]) begin
            if (phase_r[0]) begin
              phase_r[0] <= 1'b0;
              rf_r[R_SP] <= rf_r[R_SP] - 32'd4;
              adr_r <= rf_r[R_SP] - 32'd4;
              wd_r <= rf_r[R_LR];
              state_r <= S_MEMW;
            end else if (lfound) begin
              idx_r <= lpos;
              rf_r[R_SP] <= rf_r[R_SP] - 32'd4;
              adr_r <= rf_r[R_SP] - 32'd4;
              wd_r <= (base + lpos == R_SP) ? rf_r[R_SP] - 32'd4 : rf_r[base + lpos];
              state_r <= S_MEMW;
            end else state_r <= S_RSP;
          end else begin
            adr_r <= rf_r[R_SP];
            if (lfound) begin
              idx_r <= lpos + 4'd1; dst_r <= base + lpos;
              rf_r[R_SP] <= rf_r[R_SP] + 32'd4;
              state_r <= S_MEM;
            end else if (phase_r[0]) begin
              phase_r[0] <= 1'b0; dst_r <= R_PC;
              rf_r[R_SP] <= rf_r[R_SP] + 32'd4;
              state_r <= S_MEM;
            end else state_r <= S_RSP;
          end
        end
        // byte reads into wd_r, MSB first; a pulled SP is advanced past its slot
        S_MEM: begin
          phase_r[4:1] <= phase_r[4:1] + 4'd1;
          if (phase_r[1]) begin
            wd_r <= {wd_r[23:0], mrd_r};
            if (k_r == nby_r) begin
              if (ir_r[15:12] == OP_PUSH && dst_r == R_SP)
                rf_r[dst_r] <= {wd_r[23:0], mrd_r} + 32'd4;
              else
                rf_r[dst_r] <= nby_r == 2'd0 ? {24'd0, mrd_r} : {wd_r[23:0], mrd_r};
              state_r <= ir_r[15:12] == OP_PUSH ? S_LIST : S_RSP;
            end
            k_r <= k_r + 2'd1;
          end
        end
        S_MEMW: begin
          wd_r <= {wd_r[23:0], 8'd0};
          k_r <= k_r + 2'd1;
          if (k_r == nby_r)
            state_r <= ir_r[15:12] == OP_PUSH ? S_LIST : S_RSP;
        end
        S_RCLR: begin
          for (int i = 0; i < 16; i++) rf_r[i] <= '0;
          ir_r <= '0; n_r <= 1'b0; c_r <= 1'b0; z_r <= 1'b0;
          state_r <= S_RSP;
        end
        S_RSP: state_r <= S_MEMRD;
        S_MEMRD: begin
          out_r.read_byte <= mrd_r;
          out_r.reg_value <= rf_r[cmd_r.reg_select];
          out_r.program_counter <= rf_r[R_PC];
          out_r.instr_word <= ir_r;
          out_r.neg_flag <= n_r; out_r.carry_flag <= c_r; out_r.zero_flag <= z_r;
          out_r.halted <= ir_r == STOP_WORD;
          out_v_r <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          state_r <= state_nxt;
          if (out_ready) out_v_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accepted input while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed");
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.halted == (out_data.instr_word == STOP_WORD))
    else $error("halt flag mismatch");
`endif
endmodule

// ----- tb/sixteen_bit_isa_cpu_step_tb.sv -----
// ----------------------------------------------------------------------------
// sixteen_bit_isa_cpu_step_tb
// Self-checking bench for the CPU step block. A behavioral CPU model tracks
// registers, flags and memory, and predicts every result. Instructions are
// placed at the predicted PC with byte writes and then executed. Directed
// programs cover the edge cases, and random programs and noise commands run
// under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module sixteen_bit_isa_cpu_step_tb;
  import sbcpu_pkg::*;

  localparam int MEM_BYTES = 16384;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  sbcpu_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  sbcpu_out_t out_data;

  sixteen_bit_isa_cpu_step #(.MEM_BYTES(MEM_BYTES)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #2 clk = ~clk;

  // CPU model state
  logic [31:0] cpu_regs [16];
  logic [7:0]  cpu_mem [MEM_BYTES];
  logic [15:0] cpu_ir;
  logic        cpu_n, cpu_c, cpu_z;

  sbcpu_out_t  expected_q [$];
  int          errors = 0;
  int          cycles = 0;
  bit          sender_idles = 0;
  bit          receiver_stalls = 0;
  int          idle_pct = 71;
  int          hold_requests = 0;

  function automatic int phys(logic [31:0] a);
    return int'(a & 32'h3FFF) % MEM_BYTES;
  endfunction

  function automatic logic [31:0] load_word(logic [31:0] a);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < 4; k++) v = {v[23:0], cpu_mem[phys(a + k)]};
    return v;
  endfunction

  function automatic void store_word(logic [31:0] a, logic [31:0] v);
    for (int k = 0; k < 4; k++) cpu_mem[phys(a + k)] = v[31 - 8 * k -: 8];
  endfunction

  function automatic void set_nz(logic [31:0] v);
    cpu_z = (v == 0);
    cpu_n = v[31];
  endfunction

  function automatic logic [31:0] add_carry(logic [31:0] a, logic [31:0] b, logic cin);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    cpu_c = s[32];
    return s[31:0];
  endfunction

  function automatic logic [31:0] sub_borrow(logic [31:0] a, logic [31:0] b);
    cpu_c = (a >= b);
    return a - b;
  endfunction

  function automatic void alu_exec(logic [3:0] sel, logic [3:0] rd, logic [3:0] rn);
    logic [31:0] a, b, r;
    logic        wr;
    a = cpu_regs[rd];
    b = cpu_regs[rn];
    r = a;
    wr = 1'b1;
    case (sel)
      A_AND: r = a & b;
      A_EOR: r = a ^ b;
      A_SUB: r = sub_borrow(a, b);
      A_SXB: r = {{24{b[7]}}, b[7:0]};
      A_ADD: r = add_carry(a, b, 1'b0);
      A_ADC: r = add_carry(a, b, cpu_c);
      A_LSR: begin
        if (b >= 1 && b <= 32) begin
          cpu_c = a[b - 1];
          r = (b == 32) ? 32'd0 : a >> b;
        end else if (b > 32) begin
          cpu_c = 1'b0;
          r = '0;
        end
      end
      A_LSL: begin
        if (b >= 1 && b <= 32) begin
          cpu_c = a[32 - b];
          r = (b == 32) ? 32'd0 : a << b;
        end else if (b > 32) begin
          cpu_c = 1'b0;
          r = '0;
        end
      end
      A_TST: begin r = a & b; wr = 1'b0; end
      A_TEQ: begin r = a ^ b; wr = 1'b0; end
      A_CMP: begin r = sub_borrow(a, b); wr = 1'b0; end
      A_ROR: begin
        if (b != 0) begin
          cpu_c = a[(b - 1) & 31];
          if (b[4:0] != 0) r = (a >> b[4:0]) | (a << (32 - b[4:0]));
        end
      end
      A_ORR: r = a | b;
      A_MOV: r = b;
      A_BIC: r = a & ~b;
      default: r = ~b;
    endcase
    if (wr) cpu_regs[rd] = r;
    set_nz(r);
  endfunction

  function automatic logic cond_holds(logic [3:0] cc);
    case (cc)
      CC_EQ: return cpu_z;
      CC_NE: return !cpu_z;
      CC_CS: return cpu_c;
      CC_CC: return !cpu_c;
      CC_MI: return cpu_n;
      CC_PL: return !cpu_n;
      CC_HI: return cpu_c && !cpu_z;
      CC_LS: return !cpu_c && cpu_z;
      CC_AL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void stack_op(logic [15:0] w);
    int base;
    base = w[10] ? 8 : 0;
    if (!w[11]) begin
      if (w[8]) begin
        cpu_regs[R_SP] -= 4;
        store_word(cpu_regs[R_SP], cpu_regs[R_LR]);
      end
      for (int i = 7; i >= 0; i--)
        if (w[i]) begin
          cpu_regs[R_SP] -= 4;
          store_word(cpu_regs[R_SP], cpu_regs[base + i]);
        end
    end else begin
      for (int i = 0; i < 8; i++)
        if (w[i]) begin
          cpu_regs[base + i] = load_word(cpu_regs[R_SP]);
          cpu_regs[R_SP] += 4;
        end
      if (w[8]) begin
        cpu_regs[R_PC] = load_word(cpu_regs[R_SP]);
        cpu_regs[R_SP] += 4;
      end
    end
  endfunction

  function automatic void exec_instr();
    logic [31:0] pc;
    logic [15:0] w;
    logic [3:0]  rd, rn;
    logic [31:0] imm, a;
    pc = cpu_regs[R_PC];
    w = {cpu_mem[phys(pc)], cpu_mem[phys(pc + 1)]};
    cpu_regs[R_PC] = pc + 2;
    cpu_ir = w;
    rd = w[3:0];
    rn = w[7:4];
    imm = {24'd0, w[11:4]};
    case (w[15:12])
      OP_MOVI: begin cpu_regs[rd] = imm; set_nz(imm); end
      OP_CMPI: set_nz(sub_borrow(cpu_regs[rd], imm));
      OP_ADDI: begin
        cpu_regs[rd] = add_carry(cpu_regs[rd], imm, 1'b0);
        set_nz(cpu_regs[rd]);
      end
      OP_SUBI: begin
        cpu_regs[rd] = sub_borrow(cpu_regs[rd], imm);
        set_nz(cpu_regs[rd]);
      end
      OP_LDST: begin
        a = cpu_regs[rn];
        if (w[11]) cpu_regs[rd] = w[10] ? {24'd0, cpu_mem[phys(a)]} : load_word(a);
        else if (w[10]) cpu_mem[phys(a)] = cpu_regs[rd][7:0];
        else store_word(a, cpu_regs[rd]);
      end
      OP_ALU: alu_exec(w[11:8], rd, rn);
      OP_BCC: if (cond_holds(w[11:8])) cpu_regs[R_PC] += {{24{w[7]}}, w[7:0]};
      OP_B: cpu_regs[R_PC] = {20'd0, w[11:0]};
      OP_BL: begin
        cpu_regs[R_LR] = cpu_regs[R_PC];
        cpu_regs[R_PC] = {20'd0, w[11:0]};
      end
      OP_PUSH: stack_op(w);
      default: ;
    endcase
  endfunction

  function automatic void clear_cpu();
    for (int i = 0; i < 16; i++) cpu_regs[i] = '0;
    cpu_ir = '0;
    cpu_n = 1'b0;
    cpu_c = 1'b0;
    cpu_z = 1'b0;
  endfunction

  // apply one command to the model and return the expected result
  function automatic sbcpu_out_t cpu_apply(sbcpu_in_t t);
    sbcpu_out_t r;
    case (t.command)
      CMD_WRITE: cpu_mem[phys({18'd0, t.address})] = t.write_byte;
      CMD_READ: ;
      CMD_EXEC: exec_instr();
      default: clear_cpu();
    endcase
    r.read_byte = cpu_mem[phys({18'd0, t.address})];
    r.reg_value = cpu_regs[t.reg_select];
    r.program_counter = cpu_regs[R_PC];
    r.instr_word = cpu_ir;
    r.neg_flag = cpu_n;
    r.carry_flag = cpu_c;
    r.zero_flag = cpu_z;
    r.halted = (cpu_ir == STOP_WORD);
    return r;
  endfunction

  function automatic sbcpu_in_t make_cmd(logic [1:0] c, logic [13:0] a, logic [7:0] b,
                                         logic [3:0] s);
    sbcpu_in_t t;
    t.command = c;
    t.address = a;
    t.write_byte = b;
    t.reg_select = s;
    return t;
  endfunction

  // drive one transaction and hold it until accepted
  task automatic send_cmd(sbcpu_in_t t);
    in_data <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(cpu_apply(t));
    if (sender_idles && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // place an instruction at the current PC and execute it
  task automatic run_instr(logic [15:0] w);
    logic [31:0] pc;
    pc = cpu_regs[R_PC];
    send_cmd(make_cmd(CMD_WRITE, 14'(phys(pc)), w[15:8], 4'($urandom)));
    send_cmd(make_cmd(CMD_WRITE, 14'(phys(pc + 1)), w[7:0], 4'($urandom)));
    send_cmd(make_cmd(CMD_EXEC, 14'($urandom), 8'($urandom), 4'($urandom)));
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    sbcpu_out_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        e = expected_q.pop_front();
        if (out_data.read_byte != e.read_byte)
          report_mismatch("read_byte", out_data.read_byte, e.read_byte);
        if (out_data.reg_value != e.reg_value)
          report_mismatch("reg_value", out_data.reg_value, e.reg_value);
        if (out_data.program_counter != e.program_counter)
          report_mismatch("program_counter", out_data.program_counter, e.program_counter);
        if (out_data.instr_word != e.instr_word)
          report_mismatch("instr_word", out_data.instr_word, e.instr_word);
        if (out_data.neg_flag != e.neg_flag)
          report_mismatch("neg_flag", out_data.neg_flag, e.neg_flag);
        if (out_data.carry_flag != e.carry_flag)
          report_mismatch("carry_flag", out_data.carry_flag, e.carry_flag);
        if (out_data.zero_flag != e.zero_flag)
          report_mismatch("zero_flag", out_data.zero_flag, e.zero_flag);
        if (out_data.halted != e.halted)
          report_mismatch("halted", out_data.halted, e.halted);
      end
    end
  end

  // receiver stall generator, with long holds counted here
  int hold_left = 0;
  int holds_served = 0;
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(receiver_stalls && $urandom_range(99) < idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_memory_edges();
    send_cmd(make_cmd(CMD_WRITE, 14'h3FFF, 8'hFF, 4'hF));
    send_cmd(make_cmd(CMD_READ, 14'h3FFF, 8'h00, 4'h0));
    send_cmd(make_cmd(CMD_WRITE, 14'h0000, 8'h00, 4'h0));
    send_cmd(make_cmd(CMD_READ, 14'h0000, 8'hFF, 4'hF));
  endtask

  task automatic test_directed_program();
    logic [15:0] prog [$];
    prog = '{16'h4FF1, 16'h4202, 16'h4213, 16'h4004, 16'h0F55, 16'h0725,
             16'h0F55, 16'h0635, 16'h0F66, 16'h0B46, 16'h0B26, 16'h0416,
             16'h0516, 16'h0A16, 16'h0316, 16'h5FF1, 16'h7FF1, 16'h6011,
             16'h4FFD, 16'hB5FF, 16'h2C12, 16'h2412, 16'h2012, 16'h2812,
             16'hBDFF, 16'hC902, 16'hC7FE, 16'hCE02, 16'hF100, 16'hE000,
             16'hD000, 16'h1234};
    foreach (prog[i]) run_instr(prog[i]);
    // execute again after the stop word
    send_cmd(make_cmd(CMD_EXEC, 14'h0, 8'h0, 4'hF));
    // every register ALU operation
    for (int s = 0; s < 16; s++) run_instr({4'(OP_ALU), 4'(s), 4'h1, 4'h2});
    send_cmd(make_cmd(CMD_CLEAR, 14'h1555, 8'hAA, 4'hD));
  endtask

  task automatic test_random_program(int groups);
    logic [15:0] w;
    for (int g = 0; g < groups; g++) begin
      if ($urandom_range(99) < 15) begin
        send_cmd(make_cmd(2'($urandom), 14'($urandom), 8'($urandom), 4'($urandom)));
      end else begin
        w = 16'($urandom);
        // favor immediate moves so shift counts and operands stay varied
        if ($urandom_range(99) < 20) w[15:12] = OP_MOVI;
        run_instr(w);
      end
    end
  endtask

  task automatic test_backpressure();
    hold_requests++;
    for (int k = 0; k < 8; k++)
      send_cmd(make_cmd(CMD_READ, 14'($urandom), 8'($urandom), 4'($urandom)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_memory_edges();
    test_directed_program();
    test_backpressure();
    for (int m = 0; m < 4; m++) begin
      sender_idles = (m == 1) || (m == 3);
      receiver_stalls = (m == 2) || (m == 3);
      idle_pct = (m == 3) ? 37 : 71;
      test_random_program(25);
    end
    sender_idles = 0;
    receiver_stalls = 0;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // model starts from the reset state
  initial begin
    clear_cpu();
    for (int i = 0; i < MEM_BYTES; i++) cpu_mem[i] = '0;
  end

endmodule
